### hw/rtl/rfr_pkg.sv
// Shared types and codes for the radio fragment reassembler.
// No dependencies; imported by the top level and its checker.
`timescale 1ns / 1ps

package rfr_pkg;

    // Header byte layout
    localparam int unsigned LEN_W      = 6;
    localparam int unsigned OFFSET_W   = 16;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned STATUS_W   = 3;
    localparam logic [LEN_W-1:0] FIRST_HDR = 6'd3;

    // Packet types, bits 7..6 of the header
    localparam logic [1:0] KIND_ALONE = 2'd0;
    localparam logic [1:0] KIND_FIRST = 2'd1;
    localparam logic [1:0] KIND_CONT  = 2'd2;
    localparam logic [1:0] KIND_LAST  = 2'd3;

    // End-of-packet status codes
    localparam logic [STATUS_W-1:0] ST_PROGRESS  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_COMPLETE  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ACCEPTED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOSTART   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MISMATCH  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_MALFORMED = 3'd5;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              starts_packet;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   payload_byte;
        logic [OFFSET_W-1:0] payload_offset;
        logic                payload_valid;
        logic                packet_end;
        logic [STATUS_W-1:0] packet_status;
        logic [OFFSET_W-1:0] message_length;
    } out_item_t;

    // 16-bit add of a 6-bit amount, clamped at all ones
    function automatic logic [OFFSET_W-1:0] sat_add16(
        input logic [OFFSET_W-1:0] a,
        input logic [LEN_W-1:0]    b
    );
        logic [OFFSET_W:0] s;
        s = {1'b0, a} + {{(OFFSET_W + 1 - LEN_W){1'b0}}, b};
        sat_add16 = s[OFFSET_W] ? {OFFSET_W{1'b1}} : s[OFFSET_W-1:0];
    endfunction

endpackage

### hw/rtl/radio_fragment_reassembler.sv
// Radio fragment reassembler: top level, single registered stage.
// Depends on rfr_pkg for payload structs, type and status codes.
// Each accepted input transaction's result is loaded into the output register.
// Throughput: one transaction per cycle, limited only by the output register handshake.
// Reset (aresetn low, synchronous): packet state, pointers and output valid clear to zero.
// Every input transaction yields exactly one result transaction.
`timescale 1ns / 1ps

module radio_fragment_reassembler
    import rfr_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    // ------------------------------------------------------------------
    // Packet state
    // header_length_reg == 0 means no packet is open.
    // ------------------------------------------------------------------
    logic [1:0]          packet_kind_reg,     packet_kind_next;
    logic [LEN_W-1:0]    header_length_reg,   header_length_next;
    logic [LEN_W-1:0]    byte_position_reg,   byte_position_next;
    logic [OFFSET_W-1:0] write_pointer_reg,   write_pointer_next;
    logic [OFFSET_W-1:0] declared_length_reg, declared_length_next;
    logic [BYTE_W-1:0]   length_low_byte_reg, length_low_byte_next;
    logic                drop_packet_reg,     drop_packet_next;

    // Output register (the only stage between the two channels)
    logic      m_valid_reg, m_valid_next;
    out_item_t m_data_reg,  m_data_next;

    logic accept;

    // Per-transaction working values
    logic [1:0]          kind_in;
    logic [LEN_W-1:0]    len_in;
    logic [1:0]          kind_e;       // type of the packet being closed
    logic [LEN_W-1:0]    len_e;        // its length
    logic                drop_e;
    logic                do_finish;
    logic [LEN_W-1:0]    pos_inc;
    logic [LEN_W:0]      pos_plus1;
    logic [OFFSET_W-1:0] wp_sum;
    out_item_t           res;

    // Output stage accepts whenever it is empty or draining this cycle
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign kind_in   = s_data.rx_byte[7:6];
    assign len_in    = s_data.rx_byte[LEN_W-1:0];
    assign pos_inc   = byte_position_reg + 6'd1;
    assign pos_plus1 = {1'b0, pos_inc} + 7'd1;

    always_comb begin
        packet_kind_next     = packet_kind_reg;
        header_length_next   = header_length_reg;
        byte_position_next   = byte_position_reg;
        write_pointer_next   = write_pointer_reg;
        declared_length_next = declared_length_reg;
        length_low_byte_next = length_low_byte_reg;
        drop_packet_next     = drop_packet_reg;

        res        = '0;
        kind_e     = packet_kind_reg;
        len_e      = header_length_reg;
        drop_e     = drop_packet_reg;
        do_finish  = 1'b0;

        if (s_data.starts_packet) begin
            // Header byte: always abandons any open packet; opens a new one unless its length is zero
            packet_kind_next   = kind_in;
            byte_position_next = '0;
            drop_packet_next   = 1'b0;
            header_length_next = len_in;
            kind_e             = kind_in;
            len_e              = len_in;
            drop_e             = ((kind_in == KIND_FIRST) && (len_in < FIRST_HDR))
                              || ((kind_in == KIND_LAST) && (write_pointer_reg == '0));
            if (len_in == '0) begin
                // zero length closes on the header itself
                res.packet_end    = 1'b1;
                res.packet_status = ST_MALFORMED;
            end else begin
                drop_packet_next = drop_e;
                do_finish        = (len_in == 6'd1);
            end
        end else if (header_length_reg != '0) begin
            byte_position_next = pos_inc;
            if (!drop_packet_reg) begin
                case (packet_kind_reg)
                    KIND_ALONE: begin
                        res.payload_byte   = s_data.rx_byte;
                        res.payload_offset = {{(OFFSET_W-LEN_W){1'b0}}, pos_inc - 6'd1};
                        res.payload_valid  = 1'b1;
                    end
                    KIND_FIRST: begin
                        // bytes 1 and 2 carry the little-endian total length
                        if (pos_inc == 6'd1) begin
                            length_low_byte_next = s_data.rx_byte;
                        end else if (pos_inc == 6'd2) begin
                            declared_length_next = {s_data.rx_byte, length_low_byte_reg};
                        end else begin
                            res.payload_byte   = s_data.rx_byte;
                            res.payload_offset =
                                {{(OFFSET_W-LEN_W){1'b0}}, pos_inc - FIRST_HDR};
                            res.payload_valid  = 1'b1;
                        end
                    end
                    default: begin
                        // continued and last fragments append at the pointer
                        res.payload_byte   = s_data.rx_byte;
                        res.payload_offset = sat_add16(write_pointer_reg, pos_inc - 6'd1);
                        res.payload_valid  = 1'b1;
                    end
                endcase
            end
            do_finish = (pos_plus1 >= {1'b0, header_length_reg});
        end

        // Packet close: pointer bookkeeping and status
        wp_sum = sat_add16(write_pointer_reg, len_e - 6'd1);
        if (do_finish) begin
            res.packet_end    = 1'b1;
            res.packet_status = ST_ACCEPTED;
            case (kind_e)
                KIND_ALONE: begin
                    declared_length_next = {{(OFFSET_W-LEN_W){1'b0}}, len_e - 6'd1};
                    write_pointer_next   = '0;
                    res.message_length   = {{(OFFSET_W-LEN_W){1'b0}}, len_e - 6'd1};
                    res.packet_status    = ST_COMPLETE;
                end
                KIND_FIRST: begin
                    if (drop_e) begin
                        res.packet_status = ST_MALFORMED;
                    end else begin
                        write_pointer_next = {{(OFFSET_W-LEN_W){1'b0}}, len_e - FIRST_HDR};
                    end
                end
                KIND_CONT: begin
                    write_pointer_next = wp_sum;
                end
                KIND_LAST: begin
                    if (drop_e) begin
                        res.packet_status = ST_NOSTART;
                    end else if (wp_sum != declared_length_reg) begin
                        // mismatch keeps the grown pointer
                        write_pointer_next = wp_sum;
                        res.packet_status  = ST_MISMATCH;
                    end else begin
                        write_pointer_next = '0;
                        res.message_length = declared_length_reg;
                        res.packet_status  = ST_COMPLETE;
                    end
                end
                default: begin
                end
            endcase
            header_length_next = '0;
            byte_position_next = '0;
            drop_packet_next   = 1'b0;
        end

        // Output register: load on accept, else drain or hold
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (accept) begin
            m_valid_next = 1'b1;
            m_data_next  = res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            packet_kind_reg     <= '0;
            header_length_reg   <= '0;
            byte_position_reg   <= '0;
            write_pointer_reg   <= '0;
            declared_length_reg <= '0;
            length_low_byte_reg <= '0;
            drop_packet_reg     <= 1'b0;
            m_valid_reg         <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept) begin
                packet_kind_reg     <= packet_kind_next;
                header_length_reg   <= header_length_next;
                byte_position_reg   <= byte_position_next;
                write_pointer_reg   <= write_pointer_next;
                declared_length_reg <= declared_length_next;
                length_low_byte_reg <= length_low_byte_next;
                drop_packet_reg     <= drop_packet_next;
            end
        end
    end

    // payload register, no reset
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

endmodule

### hw/rtl/rfr_checker.sv
// Port-level checker for the radio fragment reassembler, with its bind.
// Depends on rfr_pkg and the top-level port list.
`timescale 1ns / 1ps

module rfr_checker
    import rfr_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // stalled result transaction holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // an input transaction always produces a result next cycle
    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("input transaction produced no result");

    // an empty output stage never back-pressures the input
    a_no_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // any status other than in-progress only on a packet's final byte
    a_end_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.packet_end == (m_data.packet_status != ST_PROGRESS)))
        else $error("packet_end and status disagree");

    // a length is reported only with a complete message; idle payload is zero
    a_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.message_length == '0) || (m_data.packet_status == ST_COMPLETE))
                 && (m_data.payload_valid
                     || ((m_data.payload_byte == '0) && (m_data.payload_offset == '0))))
        else $error("result fields inconsistent");

endmodule

bind radio_fragment_reassembler rfr_checker u_rfr_checker (.*);
